### hw/rtl/sstg_pkg.sv
package sstg_pkg;

    // Phase accumulator and sine table geometry.
    localparam int PHASE_BITS = 24;
    localparam int TABLE_BITS = 10;
    localparam int TBL_N      = 1 << TABLE_BITS;
    localparam int ROM_ADDR_W = TABLE_BITS + 1;
    localparam int PH_W       = TABLE_BITS + 2;

    // Field and register widths.
    localparam int FREQ_W   = 16;
    localparam int RATE_W   = 18;
    localparam int WEIGHT_W = 8;
    localparam int WSUM_W   = WEIGHT_W + 1;
    localparam int WORD_W   = 16;
    localparam int SINE_W   = 15;
    localparam int S_W      = SINE_W + 2;
    localparam int FRAC_W   = 15;
    localparam int NUM_W    = 26;
    localparam int DVD_W    = 24;
    localparam int QUO_W    = 16;

    // Step divider runs over the frequency bits followed by the phase fraction.
    localparam int STEP_DIV_N = FREQ_W + PHASE_BITS;
    localparam int STEP_CNT_W = $clog2(STEP_DIV_N);
    localparam int MIX_CNT_W  = $clog2(DVD_W);

    // Tick queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(44100);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);
    localparam logic                FMT_S16      = 1'b1;
    localparam logic                FMT_U8       = 1'b0;
    localparam logic [WORD_W-1:0]   U8_MID       = WORD_W'(127);

    typedef enum logic [1:0] {
        REG_TICK_RATE,
        REG_SQUARE_WEIGHT,
        REG_SINE_WEIGHT,
        REG_SAMPLE_FORMAT
    } reg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MIX,
        B_PREP,
        B_DIV,
        B_OUT
    } back_state_t;

    // One classified tick on its way to the back part.
    typedef struct packed {
        logic            silent;
        logic [PH_W-1:0] phase;
    } tick_t;

    // Mixing settings used by the back part.
    typedef struct packed {
        logic [WEIGHT_W-1:0] square_weight;
        logic [WEIGHT_W-1:0] sine_weight;
        logic                sample_format;
    } mix_cfg_t;

    typedef logic [SINE_W-1:0] rom_t [0:TBL_N];

    // Two Q30 products of a series term with the angle.
    function automatic longint taylor_mul(longint term, longint x);
        longint t;
        t = (term * x) >>> 30;
        return (t * x) >>> 30;
    endfunction

    // Quarter-wave sine table: 32767 times the sine of k table steps of a quarter turn,
    // rounded, from a Q30 Taylor series. All series terms are non-negative, so the Q30
    // rescaling is a plain shift.
    function automatic rom_t build_sine_rom();
        rom_t   rom;
        longint x;
        longint term;
        longint sum;
        longint r;
        int     k;
        for (k = 0; k <= TBL_N; k++)
        begin
            x    = (64'sd1686629713 * longint'(k)) >>> TABLE_BITS;
            term = taylor_mul(x, x) / 64'sd6;
            sum  = x - term;
            term = taylor_mul(term, x) / 64'sd20;
            sum  = sum + term;
            term = taylor_mul(term, x) / 64'sd42;
            sum  = sum - term;
            term = taylor_mul(term, x) / 64'sd72;
            sum  = sum + term;
            term = taylor_mul(term, x) / 64'sd110;
            sum  = sum - term;
            term = taylor_mul(term, x) / 64'sd156;
            sum  = sum + term;
            if (sum < 0)
            begin
                sum = 0;
            end
            r = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
            if (r > 32767)
            begin
                r = 32767;
            end
            rom[k] = SINE_W'(r);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_sine_rom();

endpackage

### hw/rtl/sstg_fifo.sv
module sstg_fifo
    import sstg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  tick_t wr_data,
    output logic  q_full,
    input  logic  rd_en,
    output tick_t rd_data,
    output logic  q_empty
);

    tick_t              mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    // Status flags from the fill count.
    assign q_full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/sstg_front.sv
module sstg_front
    import sstg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RATE_W-1:0] tick_rate,
    input  logic [FREQ_W-1:0] frequency,
    input  logic              tone_start,
    input  logic              silent,
    input  logic              push,
    output logic              full,
    output logic              q_push,
    output tick_t             q_data,
    input  logic              q_full
);

    front_state_t            state_reg;
    front_state_t            state_next;
    logic [PHASE_BITS-1:0]   phase_acc_reg;
    logic [PHASE_BITS-1:0]   phase_acc_next;
    logic [PHASE_BITS-1:0]   phase_step_reg;
    logic [PHASE_BITS-1:0]   phase_step_next;
    logic [FREQ_W-1:0]       fsh_reg;
    logic [RATE_W-1:0]       rem_reg;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic                    silent_reg;
    logic                    accept;
    logic                    div_last;
    logic [RATE_W:0]         trial;
    logic                    qbit;
    logic [RATE_W-1:0]       rem_new;

    assign accept   = push && !full;
    assign div_last = (cnt_reg == STEP_CNT_W'(STEP_DIV_N - 1));

    // One restoring step of the frequency, shifted up by PHASE_BITS, over the tick rate.
    always_comb
    begin
        trial   = {rem_reg, fsh_reg[FREQ_W-1]};
        qbit    = (trial >= {1'b0, tick_rate});
        rem_new = qbit ? RATE_W'(trial - {1'b0, tick_rate}) : RATE_W'(trial);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && tone_start)
                begin
                    state_next = (tick_rate == '0) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                if (div_last)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Outputs toward the input side and the tick queue.
    always_comb
    begin
        full          = 1'b1;
        q_push        = 1'b0;
        q_data.silent = silent;
        q_data.phase  = phase_acc_reg[PHASE_BITS-1 -: PH_W];
        case (state_reg)
            F_IDLE:
            begin
                full   = q_full;
                q_push = accept && !tone_start;
            end
            F_DIV:
            begin
                full = 1'b1;
            end
            F_PUSH:
            begin
                q_push        = !q_full;
                q_data.silent = silent_reg;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    // Phase accumulator and step register; the step shifts in quotient bits.
    always_comb
    begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && tone_start)
                begin
                    phase_acc_next = '0;
                    if (tick_rate == '0)
                    begin
                        phase_step_next = '0;
                    end
                end
                else if (accept && !silent)
                begin
                    phase_acc_next = phase_acc_reg + phase_step_reg;
                end
            end
            F_DIV:
            begin
                phase_step_next = {phase_step_reg[PHASE_BITS-2:0], qbit};
            end
            F_PUSH:
            begin
                if (!q_full && !silent_reg)
                begin
                    phase_acc_next = phase_acc_reg + phase_step_reg;
                end
            end
            default:
            begin
                phase_acc_next = phase_acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
        end
    end

    // Divider working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept && tone_start)
        begin
            fsh_reg    <= frequency;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            silent_reg <= silent;
        end
        else if (state_reg == F_DIV)
        begin
            fsh_reg <= {fsh_reg[FREQ_W-2:0], 1'b0};
            rem_reg <= rem_new;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

### hw/rtl/sstg_back.sv
module sstg_back
    import sstg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mix_cfg_t          cfg,
    input  tick_t             q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic [WORD_W-1:0] sample_word,
    output logic              empty,
    input  logic              pop
);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [WORD_W-1:0]          sample_word_reg;
    logic                       silent_reg;
    logic                       neg_reg;
    logic [SINE_W-1:0]          rom_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic [DVD_W-1:0]           dvd_reg;
    logic [WSUM_W-1:0]          rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic [MIX_CNT_W-1:0]       cnt_reg;
    logic [WSUM_W-1:0]          w_sum;
    logic [ROM_ADDR_W-1:0]      rom_addr;
    logic signed [S_W-1:0]      s_val;
    logic                       s_pos;
    logic signed [NUM_W-1:0]    sq_mag;
    logic signed [NUM_W-1:0]    sq_term;
    logic signed [NUM_W-1:0]    sin_term;
    logic signed [NUM_W-1:0]    num_mix;
    logic [NUM_W-1:0]           abs_num;
    logic [NUM_W+FRAC_W-1:0]    x16;
    logic [NUM_W-1:0]           den;
    logic [NUM_W-1:0]           t8;
    logic [NUM_W+6:0]           y8;
    logic [DVD_W-1:0]           dvd_init;
    logic [WSUM_W:0]            trial;
    logic                       qbit;
    logic [WSUM_W-1:0]          rem_new;
    logic                       out_write;
    logic [WORD_W-1:0]          word;

    assign w_sum       = {1'b0, cfg.square_weight} + {1'b0, cfg.sine_weight};
    assign sample_word = sample_word_reg;
    assign empty       = !out_valid_reg;

    // Table address: odd quadrants read the table backward.
    always_comb
    begin
        if (q_data.phase[PH_W-2])
        begin
            rom_addr = ROM_ADDR_W'(TBL_N) - {1'b0, q_data.phase[TABLE_BITS-1:0]};
        end
        else
        begin
            rom_addr = {1'b0, q_data.phase[TABLE_BITS-1:0]};
        end
    end

    // Weighted sum of square and sine, in units of 2^-15.
    always_comb
    begin
        s_val    = neg_reg ? -$signed({2'b00, rom_reg}) : $signed({2'b00, rom_reg});
        s_pos    = !neg_reg && (rom_reg != '0);
        sq_mag   = $signed({{(NUM_W - WEIGHT_W - FRAC_W){1'b0}},
                            cfg.square_weight, {FRAC_W{1'b0}}});
        sq_term  = s_pos ? sq_mag : -sq_mag;
        sin_term = NUM_W'($signed({1'b0, cfg.sine_weight})) * NUM_W'(s_val);
        num_mix  = sq_term + sin_term;
    end

    // Dividend for either format, already divided by 2^15.
    always_comb
    begin
        abs_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        x16     = {abs_num, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, abs_num};
        den     = {{(NUM_W - WSUM_W - FRAC_W){1'b0}}, w_sum, {FRAC_W{1'b0}}};
        t8      = NUM_W'(num_reg) + den;
        y8      = {t8, 7'b0} - {7'b0, t8};
        if (cfg.sample_format == FMT_S16)
        begin
            dvd_init = x16[FRAC_W +: DVD_W];
        end
        else
        begin
            dvd_init = DVD_W'(y8 >> FRAC_W);
        end
    end

    // One restoring step of the division by the weight sum.
    always_comb
    begin
        trial   = {rem_reg, dvd_reg[DVD_W-1]};
        qbit    = (trial >= {1'b0, w_sum});
        rem_new = qbit ? WSUM_W'(trial - {1'b0, w_sum}) : WSUM_W'(trial);
    end

    // Final sample word in the selected format.
    always_comb
    begin
        if (silent_reg)
        begin
            word = '0;
        end
        else if (w_sum == '0)
        begin
            word = (cfg.sample_format == FMT_S16) ? '0 : U8_MID;
        end
        else if (cfg.sample_format == FMT_S16)
        begin
            word = num_reg[NUM_W-1] ? WORD_W'(-quo_reg) : WORD_W'(quo_reg);
        end
        else
        begin
            word = {8'b0, quo_reg[7:0]};
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_MIX;
                end
            end
            B_MIX:
            begin
                state_next = silent_reg ? B_OUT : B_PREP;
            end
            B_PREP:
            begin
                state_next = (w_sum == '0) ? B_OUT : B_DIV;
            end
            B_DIV:
            begin
                if (cnt_reg == MIX_CNT_W'(DVD_W - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Queue pop and result write strobes.
    always_comb
    begin
        q_pop     = 1'b0;
        out_write = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_OUT:
            begin
                out_write = !out_valid_reg || pop;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Result register hands off to the output side.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sine table read, mixing and division datapath.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rom_reg    <= SINE_ROM[rom_addr];
            silent_reg <= q_data.silent;
            neg_reg    <= q_data.phase[PH_W-1];
        end
        if (state_reg == B_MIX)
        begin
            num_reg <= num_mix;
        end
        if (state_reg == B_PREP)
        begin
            dvd_reg <= dvd_init;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (out_write)
        begin
            sample_word_reg <= word;
        end
    end

endmodule

### hw/rtl/square_sine_tone_generator_top.sv
// Square/sine tone generator. Each input request is one sample tick and yields exactly one
// sample_word request, in order. A tick without tone_start enters while the tick queue
// has room; a tick with tone_start runs a 40-step bit-serial step divider (frequency times
// 2^24, divided by the tick rate; FREQ_W+PHASE_BITS steps) and keeps full high until the
// quotient is done and the tick is pushed into the queue (the divider is skipped when the
// rate is zero). The mixer divides tone ticks by the weight sum in a 24-step serial
// division, skipped when both weights are zero and for silent ticks, and takes one tick
// at a time. A four-entry queue between the phase front end and the mixer lets short
// silent runs and tone starts overlap. Registers on the APB port: 0x0 tick rate in
// samples per second, 0x4 square_weight, 0x8 sine_weight, 0xC sample_format (0 unsigned
// 8-bit, 1 signed 16-bit); write them only while no request is in flight.
module square_sine_tone_generator_top
    import sstg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic [FREQ_W-1:0]  frequency,
    input  logic               tone_start,
    input  logic               silent,
    input  logic               push,
    output logic               full,
    output logic [WORD_W-1:0]  sample_word,
    output logic               empty,
    input  logic               pop
);

    logic [RATE_W-1:0]   tick_rate_reg;
    logic [WEIGHT_W-1:0] square_weight_reg;
    logic [WEIGHT_W-1:0] sine_weight_reg;
    logic                sample_format_reg;
    reg_idx_t            reg_idx;
    logic                cfg_write;
    mix_cfg_t            mix_cfg;
    tick_t               fq_wr_data;
    tick_t               fq_rd_data;
    logic                fq_push;
    logic                fq_full;
    logic                fq_pop;
    logic                fq_empty;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg     <= RATE_RESET;
            square_weight_reg <= WEIGHT_RESET;
            sine_weight_reg   <= WEIGHT_RESET;
            sample_format_reg <= FMT_S16;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_TICK_RATE:     tick_rate_reg     <= pwdata[RATE_W-1:0];
                REG_SQUARE_WEIGHT: square_weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_SINE_WEIGHT:   sine_weight_reg   <= pwdata[WEIGHT_W-1:0];
                REG_SAMPLE_FORMAT: sample_format_reg <= pwdata[0];
                default:           sample_format_reg <= sample_format_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_TICK_RATE:     prdata = PDATA_W'(tick_rate_reg);
            REG_SQUARE_WEIGHT: prdata = PDATA_W'(square_weight_reg);
            REG_SINE_WEIGHT:   prdata = PDATA_W'(sine_weight_reg);
            REG_SAMPLE_FORMAT: prdata = PDATA_W'(sample_format_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        mix_cfg.square_weight = square_weight_reg;
        mix_cfg.sine_weight   = sine_weight_reg;
        mix_cfg.sample_format = sample_format_reg;
    end

    // Front end: phase accumulator and step divider.
    sstg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_rate   (tick_rate_reg),
        .frequency   (frequency),
        .tone_start  (tone_start),
        .silent      (silent),
        .push        (push),
        .full        (full),
        .q_push      (fq_push),
        .q_data      (fq_wr_data),
        .q_full      (fq_full)
    );

    // Tick queue between front end and mixer.
    sstg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wr_data),
        .q_full  (fq_full),
        .rd_en   (fq_pop),
        .rd_data (fq_rd_data),
        .q_empty (fq_empty)
    );

    // Back end: sine lookup, mixing and scaling.
    sstg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (mix_cfg),
        .q_data      (fq_rd_data),
        .q_empty     (fq_empty),
        .q_pop       (fq_pop),
        .sample_word (sample_word),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

### tb/tone_sample_checker.sv
`timescale 1ns / 100ps

module tone_sample_checker
    import sstg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic [FREQ_W-1:0]  frequency,
    input  logic               tone_start,
    input  logic               silent,
    input  logic               push,
    input  logic               full,
    input  logic [WORD_W-1:0]  sample_word,
    input  logic               empty,
    input  logic               pop,
    output int unsigned        error_count,
    output int unsigned        pending
);

    // Quarter-wave magnitude table, built locally from the Taylor series definition.
    int sine_mag [0:TBL_N];

    // Shadow copy of the registers and the oscillator state.
    logic [RATE_W-1:0]     rate_reg;
    logic [WEIGHT_W-1:0]   square_w;
    logic [WEIGHT_W-1:0]   sine_w;
    logic                  format_reg;
    logic [PHASE_BITS-1:0] phase_acc;
    logic [PHASE_BITS-1:0] phase_step;

    // Sample words still owed by the block, oldest first.
    logic [WORD_W-1:0] owed_words [$];
    int unsigned       failures;

    function automatic int quarter_sine(int k);
        longint arg;
        longint term;
        longint acc;
        longint rounded;
        int     n;
        arg  = (64'sd1686629713 * longint'(k)) / longint'(TBL_N);
        term = arg;
        acc  = arg;
        for (n = 1; n <= 6; n++)
        begin
            term = (term * arg) / 64'sd1073741824;
            term = (term * arg) / 64'sd1073741824;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc  = ((n % 2) == 1) ? acc - term : acc + term;
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        rounded = (acc * 64'sd32767 + 64'sd536870912) / 64'sd1073741824;
        return (rounded > 32767) ? 32767 : int'(rounded);
    endfunction

    initial
    begin
        int k;
        for (k = 0; k <= TBL_N; k++)
        begin
            sine_mag[k] = quarter_sine(k);
        end
    end

    // Signed sine value at a phase: the top two bits pick the quadrant.
    function automatic int signed_sine(logic [PHASE_BITS-1:0] ph);
        logic [1:0] quad;
        int         idx;
        int         mag;
        quad = ph[PHASE_BITS-1 -: 2];
        idx  = int'(ph[PHASE_BITS-3 -: TABLE_BITS]);
        mag  = quad[0] ? sine_mag[TBL_N - idx] : sine_mag[idx];
        return quad[1] ? -mag : mag;
    endfunction

    // Advance the oscillator by one tick unless silent; return its sample word.
    function automatic logic [WORD_W-1:0] synth_sample(logic [FREQ_W-1:0] freq,
                                                       logic start, logic pause);
        longint      s;
        longint      q;
        longint      num;
        longint      den;
        longint      v;
        logic [63:0] wide;
        if (start)
        begin
            phase_acc = '0;
            if (rate_reg != '0)
            begin
                wide       = ({48'd0, freq} << PHASE_BITS) / {46'd0, rate_reg};
                phase_step = wide[PHASE_BITS-1:0];
            end
            else
            begin
                phase_step = '0;
            end
        end
        if (pause)
        begin
            return '0;
        end
        s   = longint'(signed_sine(phase_acc));
        q   = (s > 0) ? 64'sd32768 : -64'sd32768;
        den = 64'sd32768 * (longint'(square_w) + longint'(sine_w));
        num = longint'(square_w) * q + longint'(sine_w) * s;
        phase_acc = phase_acc + phase_step;
        if (format_reg == FMT_S16)
        begin
            v = (den != 0) ? (64'sd32767 * num) / den : 0;
            return WORD_W'(v);
        end
        v = (den != 0) ? (64'sd127 * num + 64'sd127 * den) / den : 127;
        return WORD_W'(v & 255);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0]  want;
        logic [PDATA_W-1:0] reg_val;
        if (!rst_n)
        begin
            rate_reg   = RATE_RESET;
            square_w   = WEIGHT_RESET;
            sine_w     = WEIGHT_RESET;
            format_reg = FMT_S16;
            phase_acc  = '0;
            phase_step = '0;
            owed_words.delete();
            failures   = 0;
        end
        else
        begin
            // Register writes update the shadow copy.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TICK_RATE:     rate_reg   = pwdata[RATE_W-1:0];
                    REG_SQUARE_WEIGHT: square_w   = pwdata[WEIGHT_W-1:0];
                    REG_SINE_WEIGHT:   sine_w     = pwdata[WEIGHT_W-1:0];
                    REG_SAMPLE_FORMAT: format_reg = pwdata[0];
                    default: ;
                endcase
            end

            // Register reads must return the stored value.
            if (psel && penable && !pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TICK_RATE:     reg_val = PDATA_W'(rate_reg);
                    REG_SQUARE_WEIGHT: reg_val = PDATA_W'(square_w);
                    REG_SINE_WEIGHT:   reg_val = PDATA_W'(sine_w);
                    default:           reg_val = PDATA_W'(format_reg);
                endcase
                if (prdata !== reg_val)
                begin
                    $error("prdata mismatch at 0x%0h: expected %h, actual %h",
                           paddr, reg_val, prdata);
                    failures++;
                end
            end

            // An accepted result is compared with the oldest owed sample.
            if (pop && !empty)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("sample_word with no request outstanding: actual %h", sample_word);
                    failures++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (sample_word !== want)
                    begin
                        $error("sample_word mismatch: expected %h, actual %h",
                               want, sample_word);
                        failures++;
                    end
                end
            end

            // An accepted tick yields exactly one sample.
            if (push && !full)
            begin
                owed_words.push_back(synth_sample(frequency, tone_start, silent));
            end
        end
        pending     <= owed_words.size();
        error_count <= failures;
    end

endmodule

### tb/square_sine_tone_generator_top_test.sv
`timescale 1ns / 100ps

module square_sine_tone_generator_top_test;
    import sstg_pkg::*;

    localparam int RANDOM_TICKS = 1550;
    localparam int SETTLE_CYCLES = 80;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic [FREQ_W-1:0]  frequency;
    logic               tone_start;
    logic               silent;
    logic               push;
    logic               full;
    logic [WORD_W-1:0]  sample_word;
    logic               empty;
    logic               pop;
    int unsigned        error_count;
    int unsigned        pending;

    int burst_left;

    square_sine_tone_generator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frequency   (frequency),
        .tone_start  (tone_start),
        .silent      (silent),
        .push        (push),
        .full        (full),
        .sample_word (sample_word),
        .empty       (empty),
        .pop         (pop)
    );

    tone_sample_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .frequency   (frequency),
        .tone_start  (tone_start),
        .silent      (silent),
        .push        (push),
        .full        (full),
        .sample_word (sample_word),
        .empty       (empty),
        .pop         (pop),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The result side stalls on its own pattern, switching style after each random span.
    initial
    begin
        int mode;
        int span;
        int beat;
        pop  = 1'b0;
        beat = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 400);
            repeat (span)
            begin
                @(negedge clk);
                beat++;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    2:       pop <= ($urandom_range(0, 9) == 0);
                    default: pop <= ((beat % 7) < 3);
                endcase
            end
        end
    end

    // Present one tick and hold it until accepted; bursts are separated by random gaps, which may be zero.
    task automatic send_tick(input logic [FREQ_W-1:0] f, input logic st, input logic sl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push       <= 1'b1;
        frequency  <= f;
        tone_start <= st;
        silent     <= sl;
        do @(posedge clk); while (full);
    endtask

    // Stop sending and wait until every owed sample has come out.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [PDATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all four registers while idle, with junk above the field when asked, then read back.
    task automatic apply_settings(input logic [RATE_W-1:0] rate, input logic [WEIGHT_W-1:0] wsq,
                                  input logic [WEIGHT_W-1:0] wsin, input logic fmt,
                                  input logic dirty);
        logic [PDATA_W-1:0] junk;
        settle();
        junk = dirty ? $urandom() : '0;
        apb_access(REG_TICK_RATE, 1'b1, (junk & ~PDATA_W'(18'h3FFFF)) | PDATA_W'(rate));
        apb_access(REG_SQUARE_WEIGHT, 1'b1, (junk & ~PDATA_W'(8'hFF)) | PDATA_W'(wsq));
        apb_access(REG_SINE_WEIGHT, 1'b1, (junk & ~PDATA_W'(8'hFF)) | PDATA_W'(wsin));
        apb_access(REG_SAMPLE_FORMAT, 1'b1, (junk & ~PDATA_W'(1)) | PDATA_W'(fmt));
        apb_access(REG_TICK_RATE, 1'b0, '0);
        apb_access(REG_SQUARE_WEIGHT, 1'b0, '0);
        apb_access(REG_SINE_WEIGHT, 1'b0, '0);
        apb_access(REG_SAMPLE_FORMAT, 1'b0, '0);
    endtask

    function automatic logic [FREQ_W-1:0] pick_frequency();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            1:       return FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
            2, 3:    return FREQ_W'($urandom_range(0, 65535));
            4:       return FREQ_W'($urandom_range(1, 40));
            default: return FREQ_W'($urandom_range(20, 8000));
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            return '0;
        end
        if (pick < 6)
        begin
            return 8'hFF;
        end
        return WEIGHT_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0:       return RATE_W'(1);
            1:       return RATE_W'(196000);
            2:       return '0;
            3:       return 18'h3FFFF;
            4:       return RATE_W'(8000);
            5:       return RATE_W'(22050);
            6:       return RATE_W'(48000);
            7:       return RATE_W'(96000);
            default: return RATE_W'($urandom_range(1, 196000));
        endcase
    endfunction

    initial
    begin
        int                  sent;
        int                  phase_no;
        int                  phase_end;
        int                  run;
        logic [RATE_W-1:0]   rate;
        logic [WEIGHT_W-1:0] wsq;
        logic [WEIGHT_W-1:0] wsin;
        logic                fmt;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        frequency  = '0;
        tone_start = 1'b0;
        silent     = 1'b0;
        push       = 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a zero step, then a quarter-period step that lands on each
        // quadrant boundary, then pauses with and without a tone start.
        send_tick(16'h0000, 1'b1, 1'b0);
        send_tick(16'hFFFF, 1'b0, 1'b0);
        send_tick(16'd11025, 1'b1, 1'b0);
        repeat (4) send_tick(16'h0000, 1'b0, 1'b0);
        send_tick(16'h0000, 1'b0, 1'b1);
        send_tick(16'hFFFF, 1'b1, 1'b1);
        repeat (2) send_tick(16'h0000, 1'b0, 1'b0);

        // Both weights zero in the 8-bit format.
        apply_settings(RATE_W'(44100), '0, '0, FMT_U8, 1'b0);
        send_tick(16'd1000, 1'b1, 1'b0);
        send_tick(16'd0, 1'b0, 1'b0);

        // A zero sample rate gives a zero step; pure square mix.
        apply_settings('0, 8'hFF, '0, FMT_U8, 1'b1);
        send_tick(16'd5000, 1'b1, 1'b0);
        send_tick(16'd0, 1'b0, 1'b0);

        // Rate of 196000, pure sine.
        apply_settings(RATE_W'(196000), '0, 8'hFF, FMT_S16, 1'b0);
        send_tick(16'hFFFF, 1'b1, 1'b0);
        repeat (3) send_tick(16'h0000, 1'b0, 1'b0);

        // Rate of one makes the step wrap.
        apply_settings(RATE_W'(1), 8'hFF, 8'hFF, FMT_S16, 1'b1);
        send_tick(16'd1, 1'b1, 1'b0);
        send_tick(16'd0, 1'b0, 1'b0);

        // Phases: each a fresh setting (first four fixed, then random) and tones with random content.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS)
        begin
            case (phase_no)
                0:
                begin
                    rate = RATE_W'(44100); wsq = 8'd1; wsin = 8'd1; fmt = FMT_S16;
                end
                1:
                begin
                    rate = RATE_W'(196000); wsq = 8'hFF; wsin = 8'hFF; fmt = FMT_U8;
                end
                2:
                begin
                    rate = 18'h3FFFF; wsq = '0; wsin = '0; fmt = FMT_S16;
                end
                3:
                begin
                    rate = '0; wsq = 8'hFF; wsin = 8'd1; fmt = FMT_U8;
                end
                default:
                begin
                    rate = pick_rate();
                    wsq  = pick_weight();
                    wsin = pick_weight();
                    fmt  = 1'($urandom_range(0, 1));
                end
            endcase
            apply_settings(rate, wsq, wsin, fmt, ($urandom_range(0, 3) == 0));
            phase_end = sent + $urandom_range(100, 240);
            while (sent < phase_end && sent < RANDOM_TICKS)
            begin
                send_tick(pick_frequency(), 1'b1, ($urandom_range(0, 9) == 0));
                sent++;
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 30);
                repeat (run)
                begin
                    // Ordinary ticks carry a random frequency that the block must ignore.
                    send_tick(FREQ_W'($urandom_range(0, 65535)), 1'b0,
                              ($urandom_range(0, 7) == 0));
                    sent++;
                end
            end
            phase_no++;
        end

        settle();
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sstg_pkg.sv
hw/rtl/sstg_fifo.sv
hw/rtl/sstg_front.sv
hw/rtl/sstg_back.sv
hw/rtl/square_sine_tone_generator_top.sv
tb/tone_sample_checker.sv
tb/square_sine_tone_generator_top_test.sv
